// ===== src/huffman_table_encoder_packer_top_assert.svh =====
// Assertion macros used by the checker of the encoder.
`ifndef HUFFMAN_TABLE_ENCODER_PACKER_TOP_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_PACKER_TOP_ASSERT_SVH

`define HTE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define HTE_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

// ===== src/hte_pkg.sv =====
package hte_pkg;

    localparam int OP_W      = 2;
    localparam int SYM_W     = 8;
    localparam int WORD_BITS = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_BITS = 8;
    localparam int ACC_BITS  = 7;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOLS_DEF      = 256;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [WORD_BITS-1:0] code;
        logic [LEN_W-1:0]     len;
    } t_entry;

    function automatic int len_cap(input int max_len);
        return (max_len < WORD_BITS) ? max_len : WORD_BITS;
    endfunction

    function automatic int bytes_max(input int max_len);
        return (ACC_BITS + len_cap(max_len)) / BYTE_BITS;
    endfunction

    function automatic int word_w(input int max_len);
        return BYTE_BITS * (bytes_max(max_len) + 1);
    endfunction

endpackage

// ===== src/hte_if.sv =====
interface hte_in_if;
    logic                                valid;
    logic                                ready;
    logic [hte_pkg::OP_W-1:0]            op;
    logic [hte_pkg::SYM_W-1:0]           symbol;
    logic [hte_pkg::WORD_BITS-1:0]       code_word;
    logic [hte_pkg::LEN_W-1:0]           code_length;

    modport source (output valid, op, symbol, code_word, code_length, input ready);
    modport sink (input valid, op, symbol, code_word, code_length, output ready);
endinterface

interface hte_out_if;
    logic                                valid;
    logic                                ready;
    logic [hte_pkg::BYTE_BITS-1:0]       out_byte;
    logic                                last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== src/huffman_table_encoder_packer_top.sv =====
// Table-driven Huffman encoder with an MSB-first byte packer. A load request (op 0) writes the
// masked code word and saturated length of one symbol into the code table; an
// encode request (op 1) reads the table, appends the code to the pending bits and emits every
// completed byte; a flush request (op 2) pads pending bits with zeros, emits that byte and clears
// the packer. The last byte caused by a request carries last. Table entries hold no defined
// value until loaded, so there is no clearing pass after reset. A request emits up to four bytes
// for 32-bit codes. The output serializer sends one byte per cycle while the output is ready and
// takes a new word only as its last byte is taken. The table's read is registered alongside the
// packer's request stage and does not limit throughput.
module huffman_table_encoder_packer_top #(
    parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOLS      = hte_pkg::SYMBOLS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hte_in_if.sink    i_in,
    hte_out_if.source o_out
);

    localparam int LEN_CAP = hte_pkg::len_cap(MAX_CODE_LEN);
    localparam int IW      = $clog2(SYMBOLS);
    localparam int W       = hte_pkg::word_w(MAX_CODE_LEN);
    localparam int NBW     = $clog2(hte_pkg::bytes_max(MAX_CODE_LEN) + 1);
    localparam int MW      = hte_pkg::WORD_BITS + 1;
    localparam int SW      = hte_pkg::SYM_W + 1;

    logic                      accept;
    logic                      in_range;
    logic                      is_load;
    logic                      is_encode;
    logic                      is_flush;
    logic [hte_pkg::LEN_W-1:0] len_sat;
    logic [MW-1:0]             mask_wide;
    hte_pkg::t_entry           wr_entry;
    hte_pkg::t_entry           rd_entry;
    logic                      emit_valid;
    logic                      emit_ready;
    logic [W-1:0]              emit_word;
    logic [NBW-1:0]            emit_nbytes;

    always_comb begin
        accept    = i_in.valid && i_in.ready;
        in_range  = {1'b0, i_in.symbol} < SW'(SYMBOLS);
        is_load   = i_in.op == hte_pkg::OP_LOAD;
        is_encode = i_in.op == hte_pkg::OP_ENCODE;
        is_flush  = i_in.op == hte_pkg::OP_FLUSH;
        len_sat   = (i_in.code_length > hte_pkg::LEN_W'(LEN_CAP)) ?
                    hte_pkg::LEN_W'(LEN_CAP) : i_in.code_length;
        mask_wide = (MW'(1) << len_sat) - MW'(1);
        wr_entry.code = i_in.code_word & mask_wide[hte_pkg::WORD_BITS-1:0];
        wr_entry.len  = len_sat;
    end

    hte_table #(
        .SYMBOLS (SYMBOLS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (accept && is_load && in_range),
        .i_wr_addr (i_in.symbol[IW-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (accept && is_encode && in_range),
        .i_rd_addr (i_in.symbol[IW-1:0]),
        .o_rd_data (rd_entry)
    );

    hte_pack #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept && ((is_encode && in_range) || is_flush)),
        .i_is_flush    (is_flush),
        .i_entry       (rd_entry),
        .i_emit_ready  (emit_ready),
        .o_ready       (i_in.ready),
        .o_emit_valid  (emit_valid),
        .o_emit_word   (emit_word),
        .o_emit_nbytes (emit_nbytes)
    );

    hte_emit #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (emit_valid),
        .i_word   (emit_word),
        .i_nbytes (emit_nbytes),
        .o_ready  (emit_ready),
        .o_out    (o_out)
    );

endmodule

// ===== src/hte_table.sv =====
module hte_table #(
    parameter int SYMBOLS = hte_pkg::SYMBOLS_DEF,
    localparam int IW = $clog2(SYMBOLS)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_addr,
    input  hte_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [IW-1:0]   i_rd_addr,
    output hte_pkg::t_entry o_rd_data
);

    hte_pkg::t_entry r_mem [SYMBOLS];
    hte_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/hte_pack.sv =====
module hte_pack #(
    parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
    localparam int W   = hte_pkg::word_w(MAX_CODE_LEN),
    localparam int NBM = hte_pkg::bytes_max(MAX_CODE_LEN),
    localparam int NBW = $clog2(NBM + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_is_flush,
    input  hte_pkg::t_entry i_entry,
    input  logic            i_emit_ready,
    output logic            o_ready,
    output logic            o_emit_valid,
    output logic [W-1:0]    o_emit_word,
    output logic [NBW-1:0]  o_emit_nbytes
);

    localparam int LEN_CAP = hte_pkg::len_cap(MAX_CODE_LEN);
    localparam int CW      = $clog2(W + 1);
    localparam int AB      = hte_pkg::ACC_BITS;

    logic          r_valid;
    logic          r_flush;
    logic [AB-1:0] r_acc;
    logic [2:0]    r_cnt;

    logic [hte_pkg::LEN_W-1:0] len;
    logic [CW-1:0]             tot;
    logic [CW-1:0]             shift;
    logic [W-1:0]              acc_word;
    logic [W-1:0]              code_w;
    logic [W-1:0]              word;
    logic [NBW-1:0]            nbytes;
    logic [AB-1:0]             n_acc;
    logic [2:0]                n_cnt;
    logic                      adv;

    always_comb begin
        len = (i_entry.len > hte_pkg::LEN_W'(LEN_CAP)) ? hte_pkg::LEN_W'(LEN_CAP) : i_entry.len;
        tot = CW'(r_cnt) + CW'(len);
        shift = CW'(W) - tot;
        acc_word = {r_acc, (W - AB)'(0)};
        code_w = W'(i_entry.code);
        if (r_flush) begin
            word = acc_word;
            nbytes = (r_cnt != 3'd0) ? NBW'(1) : NBW'(0);
            n_acc = '0;
            n_cnt = 3'd0;
        end else begin
            word = acc_word | (code_w << shift);
            nbytes = NBW'(tot[CW-1:3]);
            n_cnt = tot[2:0];
            n_acc = word[W-1 -: AB];
            for (int k = 1; k <= NBM; k++) begin
                if (nbytes == NBW'(k)) begin
                    n_acc = word[W-1-hte_pkg::BYTE_BITS*k -: AB];
                end
            end
        end
        adv = r_valid && ((nbytes == NBW'(0)) || i_emit_ready);
    end

    assign o_ready       = !r_valid || adv;
    assign o_emit_valid  = r_valid && (nbytes != NBW'(0));
    assign o_emit_word   = word;
    assign o_emit_nbytes = nbytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_cnt   <= 3'd0;
        end else begin
            if (adv) begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
            end
            if (o_ready) begin
                r_valid <= i_start;
                r_flush <= i_is_flush;
            end
        end
    end

endmodule

// ===== src/hte_emit.sv =====
module hte_emit #(
    parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
    localparam int W   = hte_pkg::word_w(MAX_CODE_LEN),
    localparam int NBW = $clog2(hte_pkg::bytes_max(MAX_CODE_LEN) + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [W-1:0]   i_word,
    input  logic [NBW-1:0] i_nbytes,
    output logic           o_ready,
    hte_out_if.source      o_out
);

    logic [W-1:0]   r_word;
    logic [NBW-1:0] r_left;
    logic           take;

    assign take    = o_out.valid && o_out.ready;
    assign o_ready = (r_left == NBW'(0)) || ((r_left == NBW'(1)) && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= NBW'(0);
        end else if (i_valid && o_ready) begin
            r_word <= i_word;
            r_left <= i_nbytes;
        end else if (take) begin
            r_word <= r_word << hte_pkg::BYTE_BITS;
            r_left <= r_left - NBW'(1);
        end
    end

    assign o_out.valid    = r_left != NBW'(0);
    assign o_out.out_byte = r_word[W-1 -: hte_pkg::BYTE_BITS];
    assign o_out.last     = r_left == NBW'(1);

endmodule

// ===== src/hte_checker.sv =====
`include "huffman_table_encoder_packer_top_assert.svh"

module hte_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [hte_pkg::BYTE_BITS-1:0] i_out_byte,
    input logic                          i_out_last
);

    `HTE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last), "stalled output byte changed")
    `HTE_ASSERT_NEXT(a_burst, i_out_valid && i_out_ready && !i_out_last, i_out_valid, "bytes of one request not contiguous")
    `HTE_ASSERT_SAME(a_idle_ready, !i_out_valid, i_in_ready, "input stalled with empty output")
    `HTE_ASSERT_RESET(a_reset, !i_out_valid, "output valid after reset")

endmodule

bind huffman_table_encoder_packer_top hte_checker u_hte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);
